// ----- hdl/fp8sdp_pkg.sv -----
package fp8sdp_pkg;

  localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F32_DEF_NAN = 32'hFFC0_0000;
  localparam logic [31:0] F32_QBIT    = 32'h0040_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3,
    ST_ADD1, ST_ADD2, ST_ADD3, ST_ADD4, ST_EMIT
  } state_t;

  // which operands the shared multiplier sees
  typedef enum logic [1:0] {
    PH_PROD, PH_ROW, PH_COL
  } phase_t;

  typedef struct packed {
    logic   load_item;
    phase_t phase;
    logic   mul_s1;
    logic   mul_s2;
    logic   mul_s3;
    logic   add_s1;
    logic   add_s2;
    logic   add_s3;
    logic   add_s4;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  // first operand wins when both are NaN; result is quieted
  function automatic logic [31:0] nan_pick(input logic [31:0] a, input logic [31:0] b);
    return is_nan(a) ? (a | F32_QBIT) : (b | F32_QBIT);
  endfunction

  function automatic logic [31:0] decode_e4m3(input logic [7:0] c);
    logic [31:0] r;
    r = {c[7], 31'd0};
    if (c[6:3] == 4'hF && c[2:0] == 3'h7) begin
      r = {c[7], 31'h7FC0_0000};
    end else if (c[6:3] == 4'h0) begin
      if (c[2]) begin
        r = {c[7], 8'd120, c[1:0], 21'd0};
      end else if (c[1]) begin
        r = {c[7], 8'd119, c[0], 22'd0};
      end else if (c[0]) begin
        r = {c[7], 8'd118, 23'd0};
      end
    end else begin
      r = {c[7], 8'({4'd0, c[6:3]} + 8'd120), c[2:0], 20'd0};
    end
    return r;
  endfunction

  // m holds 1.x at bit 26 with guard, round and sticky below
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [26:0] m);
    logic [53:0] wide;
    logic [26:0] mm;
    logic [10:0] sh;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] mag;
    mm  = m;
    ef  = e[7:0];
    wide = '0;
    sh  = '0;
    inc = 1'b0;
    mag = '0;
    if (m == 27'd0) begin
      return {s, 31'd0};
    end
    if (e >= 11'sd255) begin
      return {s, 8'hFF, 23'd0};
    end
    if (e <= 11'sd0) begin
      sh = 11'(11'sd1 - e);
      if (sh > 11'd27) sh = 11'd27;
      wide = {m, 27'd0} >> sh;
      mm   = {wide[53:28], wide[27] | (|wide[26:0])};
      ef   = 8'd0;
    end
    inc = mm[2] & (mm[3] | mm[1] | mm[0]);
    mag = {ef, mm[25:3]} + {30'd0, inc};
    return {s, mag};
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] p);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (p[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] p);
    logic [4:0] lz;
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (p[i]) lz = 5'(27 - i);
    end
    return lz;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] t;
    t = u + 32'h0000_7FFF + {31'd0, u[16]};
    if (is_nan(u)) return u[31:16] | 16'h0040;
    return t[31:16];
  endfunction

endpackage

// ----- hdl/fp8sdp_ctrl.sv -----
module fp8sdp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  fp8sdp_pkg::status_t status,
  output fp8sdp_pkg::cmd_t    cmd
);
  import fp8sdp_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  // hold state, phase and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_PROD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequence one item through multiply, add and the scale steps
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase = phase_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          phase_nxt     = PH_PROD;
          state_nxt     = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul_s1 = 1'b1;
        state_nxt  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_s2 = 1'b1;
        state_nxt  = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul_s3 = 1'b1;
        case (phase_r)
          PH_PROD: state_nxt = ST_ADD1;
          PH_ROW: begin
            phase_nxt = PH_COL;
            state_nxt = ST_MUL1;
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_ADD1: begin
        cmd.add_s1 = 1'b1;
        state_nxt  = ST_ADD2;
      end
      ST_ADD2: begin
        cmd.add_s2 = 1'b1;
        state_nxt  = ST_ADD3;
      end
      ST_ADD3: begin
        cmd.add_s3 = 1'b1;
        state_nxt  = ST_ADD4;
      end
      ST_ADD4: begin
        cmd.add_s4 = 1'b1;
        if (status.last) begin
          phase_nxt = PH_ROW;
          state_nxt = ST_MUL1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // drop the result flag once taken, raise it on emit
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.emit)   out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input ready while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result overwritten before taken");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_MUL1 && phase_r == PH_PROD))
    else $error("accepted item did not start multiply");
`endif

endmodule

// ----- hdl/fp8sdp_datapath.sv -----
module fp8sdp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic [87:0]         in_tdata,
  input  logic                in_tlast,
  output logic [15:0]         out_tdata,
  input  fp8sdp_pkg::cmd_t    cmd,
  output fp8sdp_pkg::status_t status
);
  import fp8sdp_pkg::*;

  logic        mode_r;
  logic [31:0] act_r, wgt_r, rs_r, cs_r;
  logic        last_r;
  logic [31:0] acc_r, res_r;
  logic [15:0] out_r;

  // multiplier stage registers
  logic [47:0] mp_r;
  logic [8:0]  me_r;
  logic        ms_r, mspec_r;
  logic [31:0] mspecv_r;
  logic [5:0]  mlz_r;

  // adder stage registers
  logic [26:0] al_r, as_r;
  logic [7:0]  ael_r;
  logic        asl_r, asub_r, azs_r, aspec_r;
  logic [31:0] aspecv_r;
  logic [27:0] ar_r;
  logic [4:0]  alz_r;

  logic [31:0] ma, mb;
  logic [31:0] act_dec;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign act_dec = mode_r ? decode_e4m3(in_tdata[7:0]) : {in_tdata[15:0], 16'd0};

  // multiplier operands by phase
  always_comb begin
    case (cmd.phase)
      PH_PROD: begin
        ma = act_r;
        mb = wgt_r;
      end
      PH_ROW: begin
        ma = acc_r;
        mb = mode_r ? rs_r : F32_ONE;
      end
      default: begin
        ma = res_r;
        mb = cs_r;
      end
    endcase
  end

  // multiply stage one: unpack, specials, significand product
  logic [23:0] mma, mmb;
  logic [8:0]  mea, meb;
  logic        mzero_a, mzero_b;
  always_comb begin
    mma = {ma[30:23] != 8'd0, ma[22:0]};
    mmb = {mb[30:23] != 8'd0, mb[22:0]};
    mea = (ma[30:23] == 8'd0) ? 9'd1 : {1'b0, ma[30:23]};
    meb = (mb[30:23] == 8'd0) ? 9'd1 : {1'b0, mb[30:23]};
    mzero_a = ma[30:0] == 31'd0;
    mzero_b = mb[30:0] == 31'd0;
  end

  // multiply stage three: normalize and round
  logic [47:0]        mpn;
  logic signed [10:0] mexp;
  logic [31:0]        mres;
  always_comb begin
    mpn  = mp_r << mlz_r;
    mexp = $signed({2'b00, me_r}) - $signed({5'd0, mlz_r}) - 11'sd126;
    mres = mspec_r ? mspecv_r : round_pack(ms_r, mexp, {mpn[47:22], |mpn[21:0]});
  end

  // add stage one: order by magnitude and align the smaller operand
  logic [31:0] xa, xb, xl, xs;
  logic [7:0]  el, es, dd;
  logic [53:0] aw;
  logic [26:0] sml;
  always_comb begin
    xa = acc_r;
    xb = res_r;
    if (xa[30:0] >= xb[30:0]) begin
      xl = xa;
      xs = xb;
    end else begin
      xl = xb;
      xs = xa;
    end
    el = (xl[30:23] == 8'd0) ? 8'd1 : xl[30:23];
    es = (xs[30:23] == 8'd0) ? 8'd1 : xs[30:23];
    dd = el - es;
    if (dd > 8'd27) dd = 8'd27;
    aw  = {xs[30:23] != 8'd0, xs[22:0], 3'd0, 27'd0} >> dd;
    sml = {aw[53:28], aw[27] | (|aw[26:0])};
  end

  // add stage four: normalize and round
  logic [27:0]        apn;
  logic signed [10:0] aexp;
  logic [31:0]        ares;
  always_comb begin
    apn  = ar_r << alz_r;
    aexp = $signed({3'd0, ael_r}) + 11'sd1 - $signed({6'd0, alz_r});
    if (aspec_r) begin
      ares = aspecv_r;
    end else if (ar_r == 28'd0) begin
      ares = {azs_r, 31'd0};
    end else begin
      ares = round_pack(asl_r, aexp, {apn[27:2], |apn[1:0]});
    end
  end

  always_ff @(posedge clk) begin
    // capture the item
    if (cmd.load_item) begin
      act_r  <= act_dec;
      wgt_r  <= decode_e4m3(in_tdata[23:16]);
      rs_r   <= in_tdata[55:24];
      cs_r   <= in_tdata[87:56];
      last_r <= in_tlast;
    end
    if (cmd.mul_s1) begin
      mp_r     <= mma * mmb;
      me_r     <= mea + meb;
      ms_r     <= ma[31] ^ mb[31];
      mspec_r  <= 1'b1;
      if (is_nan(ma) || is_nan(mb)) begin
        mspecv_r <= nan_pick(ma, mb);
      end else if ((is_inf(ma) && mzero_b) || (is_inf(mb) && mzero_a)) begin
        mspecv_r <= F32_DEF_NAN;
      end else if (is_inf(ma) || is_inf(mb)) begin
        mspecv_r <= {ma[31] ^ mb[31], 8'hFF, 23'd0};
      end else begin
        mspec_r  <= 1'b0;
        mspecv_r <= '0;
      end
    end
    if (cmd.mul_s2) begin
      mlz_r <= lzc48(mp_r);
    end
    if (cmd.mul_s3) begin
      res_r <= mres;
    end
    if (cmd.add_s1) begin
      al_r    <= {el == 8'd1 && xl[30:23] == 8'd0 ? 1'b0 : 1'b1, xl[22:0], 3'd0};
      as_r    <= sml;
      ael_r   <= el;
      asl_r   <= xl[31];
      asub_r  <= xl[31] ^ xs[31];
      azs_r   <= xa[31] & xb[31];
      aspec_r <= 1'b1;
      if (is_nan(xa) || is_nan(xb)) begin
        aspecv_r <= nan_pick(xa, xb);
      end else if (is_inf(xa) && is_inf(xb) && (xa[31] != xb[31])) begin
        aspecv_r <= F32_DEF_NAN;
      end else if (is_inf(xa)) begin
        aspecv_r <= xa;
      end else if (is_inf(xb)) begin
        aspecv_r <= xb;
      end else begin
        aspec_r  <= 1'b0;
        aspecv_r <= '0;
      end
    end
    if (cmd.add_s2) begin
      ar_r <= asub_r ? ({1'b0, al_r} - {1'b0, as_r}) : ({1'b0, al_r} + {1'b0, as_r});
    end
    if (cmd.add_s3) begin
      alz_r <= lzc28(ar_r);
    end
    if (cmd.emit) begin
      out_r <= to_bf16(res_r);
    end
  end

  // accumulator: advance on add, clear after a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.emit) begin
      acc_r <= '0;
    end else if (cmd.add_s4) begin
      acc_r <= ares;
    end
  end

  assign out_tdata   = out_r;
  assign status.last = last_r;

endmodule

// ----- hdl/fp8_scaled_dot_product_unit.sv -----
// Dot product of activation and e4m3 weight pairs with an f32 accumulator.
// Activations are bf16, or e4m3 in the low byte when cfg_wdata has written
// a one into the mode register. Each item is decoded, multiplied and added
// in order with round-to-nearest-even; on the item with in_tlast set the sum
// is scaled by the row scale (fp8 mode only) and the column scale, and one
// bf16 result leaves on the out_ channel, after which the sum restarts at
// +0.0. The single shared f32 multiplier steps through MUL1 to MUL3 per use
// and the adder through ADD1 to ADD4; a new item is taken only once the last
// is through. A last item ends by loading the output register, which frees
// the input side while the result waits.
module fp8_scaled_dot_product_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // activation[15:0], weight_code[23:16], row_scale[55:24], column_scale[87:56]
  input  logic [87:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_bf16[15:0]
  output logic [15:0] out_tdata
);
  import fp8sdp_pkg::*;

  cmd_t    cmd;
  status_t status;

  fp8sdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fp8sdp_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .out_tdata(out_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import fp8sdp_pkg::*;

  localparam int  DRAIN_CYCLES = 20;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  RANDOM_ITEMS = 500;
  localparam int  PHASE_ITEMS  = 100;
  localparam logic [31:0] F32_INF = 32'h7F80_0000;

  // one directed item: mode, fields, and a hand-typed result where obvious
  typedef struct packed {
    logic        mode;
    logic [15:0] act;
    logic [7:0]  wgt;
    logic [31:0] rs;
    logic [31:0] cs;
    logic        last;
    logic        known;
    logic [15:0] res;
  } vec_t;

  // split f32: magnitude as integer m times 2^e
  typedef struct {
    logic        s;
    logic [23:0] m;
    int          e;
  } f32_parts_t;

  localparam int NVEC = 17;
  localparam vec_t VECS [NVEC] = '{
    '{1'b0, 16'h3F80, 8'h38, 32'h0, 32'h3F80_0000, 1'b1, 1'b1, 16'h3F80},
    '{1'b0, 16'h3F80, 8'h7F, 32'h0, 32'h3F80_0000, 1'b1, 1'b1, 16'h7FC0},
    '{1'b0, 16'hFF80, 8'h00, 32'h0, 32'h3F80_0000, 1'b1, 1'b1, 16'hFFC0},
    '{1'b0, 16'h7F7F, 8'h7E, 32'h0, 32'h0,         1'b0, 1'b0, 16'h0},
    '{1'b0, 16'h7F7F, 8'h7E, 32'h0, 32'h3F80_0000, 1'b1, 1'b1, 16'h7F80},
    '{1'b0, 16'h3F80, 8'h01, 32'h0, 32'h3F80_0000, 1'b1, 1'b1, 16'h3B00},
    '{1'b0, 16'hFFFF, 8'h38, 32'h0, 32'h3F80_0000, 1'b1, 1'b1, 16'hFFFF},
    '{1'b0, 16'h8000, 8'h80, 32'hFFFF_FFFF, 32'h3F80_0000, 1'b1, 1'b0, 16'h0},
    '{1'b0, 16'h0000, 8'hFF, 32'h0, 32'h3F80_0000, 1'b1, 1'b0, 16'h0},
    '{1'b0, 16'h4049, 8'hB8, 32'h0, 32'h0,         1'b0, 1'b0, 16'h0},
    '{1'b0, 16'hC000, 8'h46, 32'h0, 32'h4040_0000, 1'b1, 1'b0, 16'h0},
    '{1'b1, 16'hAB38, 8'h38, 32'h4000_0000, 32'h3F80_0000, 1'b1, 1'b1, 16'h4000},
    '{1'b1, 16'h007F, 8'h38, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1, 16'h7FC0},
    '{1'b1, 16'h0038, 8'h38, 32'h0000_0000, 32'h7F80_0000, 1'b1, 1'b0, 16'h0},
    '{1'b1, 16'h0077, 8'h77, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 1'b0, 16'h0},
    '{1'b1, 16'h0001, 8'h01, 32'h0000_0001, 32'h3F80_0000, 1'b1, 1'b0, 16'h0},
    '{1'b1, 16'hFF80, 8'h07, 32'hBF80_0000, 32'h0000_0001, 1'b1, 1'b0, 16'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // predictor state and expected results
  logic [31:0] acc_bits = 32'h0;
  logic        fp8_mode = 1'b0;
  logic [15:0] pending_results [$];
  logic        item_known = 1'b0;
  logic [15:0] item_result = 16'h0;
  logic        calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;

  fp8_scaled_dot_product_unit uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic f_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    return (x[30:0] == F32_INF[30:0]);
  endfunction

  function automatic f32_parts_t unpack_f32(input logic [31:0] x);
    f32_parts_t p;
    p.s = x[31];
    if (x[30:23] == 8'd0) begin
      p.m = {1'b0, x[22:0]};
      p.e = -149;
    end else begin
      p.m = {1'b1, x[22:0]};
      p.e = int'(x[30:23]) - 150;
    end
    return p;
  endfunction

  // round m * 2^e to f32, nearest-even, subnormals kept
  function automatic logic [31:0] round_f32(input logic s, input logic [319:0] m,
                                            input int e);
    int p, be, sh;
    logic [319:0] q, rem, half;
    longint bits;
    p = 0;
    if (m == '0) return {s, 31'd0};
    for (int i = 0; i < 320; i++) if (m[i]) p = i;
    be = p + e + 127;
    if (be < 1) be = 1;
    sh = be - 150 - e;
    if (sh > 0) begin
      q = m >> sh;
      rem = m & ((320'd1 << sh) - 320'd1);
      half = 320'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 320'd1;
    end else begin
      q = m << (-sh);
    end
    bits = longint'(be - 1) * 64'd8388608 + longint'(q[31:0]);
    if (bits >= longint'(F32_INF)) return {s, F32_INF[30:0]};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    f32_parts_t pa, pb;
    logic s;
    if (f_nan(a)) return a | F32_QBIT;
    if (f_nan(b)) return b | F32_QBIT;
    s = a[31] ^ b[31];
    if (f_inf(a) || f_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return F32_DEF_NAN;
      return {s, F32_INF[30:0]};
    end
    pa = unpack_f32(a);
    pb = unpack_f32(b);
    return round_f32(s, 320'(pa.m) * 320'(pb.m), pa.e + pb.e);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    f32_parts_t pa, pb;
    logic [319:0] ma, mb, m;
    logic s;
    int emin;
    if (f_nan(a)) return a | F32_QBIT;
    if (f_nan(b)) return b | F32_QBIT;
    if (f_inf(a) && f_inf(b) && a[31] != b[31]) return F32_DEF_NAN;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    pa = unpack_f32(a);
    pb = unpack_f32(b);
    emin = (pa.e < pb.e) ? pa.e : pb.e;
    ma = 320'(pa.m) << (pa.e - emin);
    mb = 320'(pb.m) << (pb.e - emin);
    if (pa.s == pb.s) begin
      m = ma + mb;
      s = pa.s;
    end else if (ma >= mb) begin
      m = ma - mb;
      s = pa.s;
    end else begin
      m = mb - ma;
      s = pb.s;
    end
    // exact cancellation gives +0; two zeros of one sign keep it
    if (m == '0) return {(pa.s == pb.s) ? pa.s : 1'b0, 31'd0};
    return round_f32(s, m, emin);
  endfunction

  function automatic logic [31:0] e4m3_to_f32(input logic [7:0] c);
    if (c[6:3] == 4'hF && c[2:0] == 3'h7) return {c[7], 31'h7FC0_0000};
    if (c[6:3] == 4'h0) return round_f32(c[7], 320'(c[2:0]), -9);
    return {c[7], 4'd0, c[6:3], c[2:0], 20'd0} + {1'b0, 8'd120, 23'd0};
  endfunction

  function automatic logic [15:0] f32_to_bf16(input logic [31:0] u);
    logic [31:0] t;
    if (f_nan(u)) return u[31:16] | 16'h0040;
    t = u + 32'h0000_7FFF + {31'd0, u[16]};
    return t[31:16];
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // predict on accepted items, track mode writes, check results
  always @(posedge clk) begin
    logic [31:0] a, w, sum, scaled;
    logic [15:0] want;
    cycles++;
    if (rst_n && cfg_we) fp8_mode = cfg_wdata;
    if (rst_n && in_tvalid && in_tready) begin
      a = fp8_mode ? e4m3_to_f32(in_tdata[7:0]) : {in_tdata[15:0], 16'h0};
      w = e4m3_to_f32(in_tdata[23:16]);
      sum = f32_add(acc_bits, f32_mul(a, w));
      acc_bits = sum;
      if (in_tlast) begin
        scaled = f32_mul(sum, fp8_mode ? in_tdata[55:24] : F32_ONE);
        scaled = f32_mul(scaled, in_tdata[87:56]);
        pending_results.push_back(item_known ? item_result : f32_to_bf16(scaled));
        acc_bits = 32'h0;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_tdata, 16'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want) report("result_bf16", out_tdata, want);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall before each result
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = calm ? 0 : $urandom_range(0, 9);
      if (k > 0) begin
        out_tready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [15:0] act, input logic [7:0] wgt, input logic [31:0] rs,
                           input logic [31:0] cs, input logic last, input logic known,
                           input logic [15:0] res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {cs, rs, wgt, act};
    in_tlast <= last;
    item_known <= known;
    item_result <= res;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_scale();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
  endfunction

  initial begin
    logic mode_now;
    logic [15:0] act;
    int sent, run, phase;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    mode_now = 1'b0;
    write_mode(1'b0);
    for (int i = 0; i < NVEC; i++) begin
      if (VECS[i].mode != mode_now) begin
        mode_now = VECS[i].mode;
        write_mode(mode_now);
      end
      send_item(VECS[i].act, VECS[i].wgt, VECS[i].rs, VECS[i].cs, VECS[i].last,
                VECS[i].known, VECS[i].res);
    end

    // random phases, each under a fresh mode setting
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode_now = (phase < 2) ? phase[0] : 1'($urandom);
      write_mode(mode_now);
      calm = (phase % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; ) begin
        run = $urandom_range(1, 8);
        for (int j = 0; j < run; j++) begin
          if (mode_now || $urandom_range(0, 7) == 0) act = $urandom;
          else act = {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
          send_item(act, 8'($urandom), rand_scale(), rand_scale(), j == run - 1,
                    1'b0, 16'h0);
          n++;
          sent++;
        end
      end
      phase++;
    end

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
